/* sv/lkv_pkg.sv */
// Shared constants, state codes and types of the LRU key-value cache.
package lkv_pkg;

	localparam int KEY_W        = 16;
	localparam int VALUE_W      = 32;
	localparam int CAP_W        = 5;
	localparam int CAP_RESET    = 16;
	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 16;
	localparam int VAL_BITS_DEF = 32;
	localparam int S_DATA_W     = 48;
	localparam int M_DATA_W     = 48;
	localparam int M_USER_W     = 2;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] read_value;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
	} res_t;

endpackage

/* sv/lkv_store.sv */
// Key and value memories of the cache: one write port, one registered read port.
module lkv_store #(
	parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
	parameter int KW = lkv_pkg::KEY_BITS_DEF,
	parameter int VW = lkv_pkg::VAL_BITS_DEF,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [KW-1:0]    wkey,
	input  logic [VW-1:0]    wval,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [KW-1:0]    rkey,
	output logic [VW-1:0]    rval
);

	logic [KW-1:0] key_mem [ENTRIES];
	logic [VW-1:0] val_mem [ENTRIES];
	logic [KW-1:0] rkey_q;
	logic [VW-1:0] rval_q;

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
		if (re) begin
			rkey_q <= key_mem[raddr];
			rval_q <= val_mem[raddr];
		end
	end

	assign rkey = rkey_q;
	assign rval = rval_q;

endmodule

/* sv/lkv_ctrl.sv */
// Sequencer of the cache: serial key compare over the store, recency ranks and update.
module lkv_ctrl #(
	parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
	parameter int KW = lkv_pkg::KEY_BITS_DEF,
	parameter int VW = lkv_pkg::VAL_BITS_DEF,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     req_put,
	input  logic [KW-1:0]            req_key,
	input  logic [VW-1:0]            req_val,
	input  logic [lkv_pkg::CAP_W-1:0] cap,
	input  logic                     out_free,
	output logic                     idle,
	output logic                     done,
	output lkv_pkg::res_t            res,
	output logic                     st_we,
	output logic [IDX_W-1:0]         st_waddr,
	output logic [KW-1:0]            st_wkey,
	output logic [VW-1:0]            st_wval,
	output logic                     st_re,
	output logic [IDX_W-1:0]         st_raddr,
	input  logic [KW-1:0]            st_rkey,
	input  logic [VW-1:0]            st_rval
);

	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int RANK_W  = IDX_W;
	localparam int CAP_W   = lkv_pkg::CAP_W;
	localparam int CMP_W   = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
	localparam int KEY_W   = lkv_pkg::KEY_W;
	localparam int VALUE_W = lkv_pkg::VALUE_W;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  fill_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              put_q;
	logic [KW-1:0]     key_q;
	logic [VW-1:0]     val_q;
	logic [ENTRIES-1:0] valid_q;
	logic [RANK_W-1:0] rank_q [ENTRIES];

	logic              found_q;
	logic [IDX_W-1:0]  found_idx_q;
	logic [RANK_W-1:0] found_rank_q;
	logic [VW-1:0]     found_val_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [RANK_W-1:0] best_rank_q;
	logic [KW-1:0]     best_key_q;

	logic              issue;
	logic              match;
	logic              take_free;
	logic              take_best;
	logic              scan_end;
	logic              commit;
	logic [CMP_W-1:0]  cap_x;
	logic [CMP_W-1:0]  ent_x;
	logic [CMP_W-1:0]  fill_x;
	logic [CMP_W-1:0]  eff_cap;
	logic              fill_ok;
	logic              do_fill;
	logic              do_evict;
	logic              do_touch;
	logic [IDX_W-1:0]  slot;
	logic [RANK_W-1:0] touch_rank;

	assign issue     = (state_q == lkv_pkg::ST_SCAN) && (cnt_q != CNT_W'(ENTRIES));
	assign st_re     = issue;
	assign st_raddr  = cnt_q[IDX_W-1:0];
	assign match     = rd_vld_s1 && valid_q[idx_s1] && (st_rkey == key_q) && !found_q;
	assign take_free = rd_vld_s1 && !valid_q[idx_s1] && !free_q;
	assign take_best = rd_vld_s1 && valid_q[idx_s1] &&
		(!best_q || (rank_q[idx_s1] > best_rank_q));
	assign scan_end  = (state_q == lkv_pkg::ST_SCAN) && (cnt_q == CNT_W'(ENTRIES)) &&
		!rd_vld_s1;
	assign commit    = (state_q == lkv_pkg::ST_UPD) && out_free;

	always_comb begin
		cap_x  = CMP_W'(cap);
		ent_x  = CMP_W'(ENTRIES);
		fill_x = CMP_W'(fill_q);
		if (cap_x == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_x > ent_x) begin
			eff_cap = ent_x;
		end else begin
			eff_cap = cap_x;
		end
		fill_ok = (fill_x < eff_cap) && (fill_x < ent_x);
	end

	assign do_fill    = !found_q && (put_q == lkv_pkg::ACT_PUT) && fill_ok && free_q;
	assign do_evict   = !found_q && (put_q == lkv_pkg::ACT_PUT) && !do_fill && best_q;
	assign do_touch   = found_q || do_evict;
	assign slot       = found_q ? found_idx_q : (do_fill ? free_idx_q : best_idx_q);
	assign touch_rank = found_q ? found_rank_q : best_rank_q;

	assign st_we    = commit && ((found_q && (put_q == lkv_pkg::ACT_PUT)) || do_fill || do_evict);
	assign st_waddr = slot;
	assign st_wkey  = key_q;
	assign st_wval  = val_q;

	assign idle = (state_q == lkv_pkg::ST_IDLE);
	assign done = commit;

	always_comb begin
		res.hit         = found_q;
		res.read_value  = (found_q && (put_q == lkv_pkg::ACT_GET)) ?
			VALUE_W'(found_val_q) : '0;
		res.evicted     = do_evict;
		res.evicted_key = do_evict ? KEY_W'(best_key_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lkv_pkg::ST_IDLE;
			cnt_q     <= '0;
			fill_q    <= '0;
			rd_vld_s1 <= 1'b0;
			valid_q   <= '0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			best_q    <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				lkv_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= lkv_pkg::ST_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						best_q  <= 1'b0;
					end
				end
				lkv_pkg::ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (match) begin
						found_q <= 1'b1;
					end
					if (take_free) begin
						free_q <= 1'b1;
					end
					if (take_best) begin
						best_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= lkv_pkg::ST_UPD;
					end
				end
				lkv_pkg::ST_UPD: begin
					if (commit) begin
						state_q <= lkv_pkg::ST_IDLE;
						for (int i = 0; i < ENTRIES; i++) begin
							if (do_fill && valid_q[i]) begin
								rank_q[i] <= rank_q[i] + RANK_W'(1);
							end else if (do_touch && valid_q[i] &&
								(IDX_W'(i) != slot) && (rank_q[i] < touch_rank)) begin
								rank_q[i] <= rank_q[i] + RANK_W'(1);
							end
						end
						if (do_fill || do_touch) begin
							rank_q[slot] <= '0;
						end
						if (do_fill) begin
							valid_q[slot] <= 1'b1;
							fill_q        <= fill_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= lkv_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (idle && start) begin
			put_q <= req_put;
			key_q <= req_key;
			val_q <= req_val;
		end
		if (match) begin
			found_idx_q  <= idx_s1;
			found_rank_q <= rank_q[idx_s1];
			found_val_q  <= st_rval;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
		if (take_best) begin
			best_idx_q  <= idx_s1;
			best_rank_q <= rank_q[idx_s1];
			best_key_q  <= st_rkey;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("fill count above entry count");

	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(fill_q))
		else $error("fill count disagrees with valid marks");

	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (state_q == lkv_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after update");

	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.evicted) |-> (!res.hit && (put_q == lkv_pkg::ACT_PUT)))
		else $error("eviction reported on a hit or a get");

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && start) |=> ((state_q == lkv_pkg::ST_SCAN) && (cnt_q == '0)))
		else $error("accepted transfer did not start a scan");

endmodule

/* sv/lru_key_value_cache.sv */
// Top level of the LRU key-value cache: stream ports, capacity register, result register.
//
// Usage: one request per slave transfer. s_tuser carries the action (0 get, 1 put),
// s_tdata the key and the value of a put. Each request yields exactly one master
// transfer: m_tuser flags hit and eviction, m_tdata the value read by a get hit and
// the key removed by an eviction (zeros where not applicable).
// A single key comparator walks the entries one per cycle through the store's read
// port, then the update step applies the write and the recency update once the output
// register is free. s_tready is low from the time a request is taken until its
// update is done, so a new request is taken only after the previous one completes.
// The result sits in an output register; while m_tready is low the block finishes
// the lookup and then waits in its update step, so no result is lost or repeated.
// cfg_we writes capacity_in_use from cfg_wdata; 0 acts as 1, values above ENTRIES
// act as ENTRIES. Write it only while no request is in flight.
// Reset clears all valid marks, recency ranks and the fill count, sets the capacity
// to 16 and drops any pending result. Key and value storage is not cleared.
module lru_key_value_cache #(
	parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VAL_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lkv_pkg::S_DATA_W-1:0] s_tdata,  // lookup_key, store_value
	input  logic                         s_tuser,  // action
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lkv_pkg::M_DATA_W-1:0] m_tdata,  // read_value, evicted_key
	output logic [lkv_pkg::M_USER_W-1:0] m_tuser,  // hit, evicted
	input  logic                         cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]    cfg_wdata
);

	localparam int KEY_W   = lkv_pkg::KEY_W;
	localparam int VALUE_W = lkv_pkg::VALUE_W;
	localparam int KW      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int VW      = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [lkv_pkg::CAP_W-1:0] cap_q;
	logic                      m_tvalid_q;
	lkv_pkg::res_t             res_q;
	lkv_pkg::res_t             res;
	logic                      idle;
	logic                      done;
	logic                      start;
	logic                      out_free;
	logic                      st_we;
	logic [IDX_W-1:0]          st_waddr;
	logic [KW-1:0]             st_wkey;
	logic [VW-1:0]             st_wval;
	logic                      st_re;
	logic [IDX_W-1:0]          st_raddr;
	logic [KW-1:0]             st_rkey;
	logic [VW-1:0]             st_rval;

	assign s_tready = idle;
	assign start    = s_tvalid && idle;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {res_q.evicted_key, res_q.read_value};
	assign m_tuser  = {res_q.evicted, res_q.hit};

	lkv_ctrl #(
		.ENTRIES(ENTRIES),
		.KW(KW),
		.VW(VW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_put(s_tuser),
		.req_key(s_tdata[KW-1:0]),
		.req_val(s_tdata[KEY_W +: VW]),
		.cap(cap_q),
		.out_free(out_free),
		.idle(idle),
		.done(done),
		.res(res),
		.st_we(st_we),
		.st_waddr(st_waddr),
		.st_wkey(st_wkey),
		.st_wval(st_wval),
		.st_re(st_re),
		.st_raddr(st_raddr),
		.st_rkey(st_rkey),
		.st_rval(st_rval)
	);

	lkv_store #(
		.ENTRIES(ENTRIES),
		.KW(KW),
		.VW(VW)
	) u_store (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wkey(st_wkey),
		.wval(st_wval),
		.re(st_re),
		.raddr(st_raddr),
		.rkey(st_rkey),
		.rval(st_rval)
	);

endmodule

/* bench/lru_key_value_cache_test.sv */
// Self-checking stream testbench for the LRU key-value cache with directed and random requests.
module lru_key_value_cache_test;

	typedef struct packed {
		logic                        act;
		logic [lkv_pkg::KEY_W-1:0]   key;
		logic [lkv_pkg::VALUE_W-1:0] val;
		logic                        typed;
		lkv_pkg::res_t               want;
	} probe_row_t;

	localparam lkv_pkg::res_t ZERO_RES = '0;
	localparam int N_PROBES = 25;
	localparam int N_PHASES = 8;
	localparam int PHASE_LEN = 156;
	localparam int N_SLOTS = lkv_pkg::ENTRIES_DEF;

	localparam probe_row_t PROBES [N_PROBES] = '{
		'{lkv_pkg::ACT_GET, 16'h0000, 32'h0000_0000, 1'b1, ZERO_RES},
		'{lkv_pkg::ACT_GET, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0000, 32'h0000_0000, 1'b1, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ZERO_RES},
		'{lkv_pkg::ACT_GET, 16'hFFFF, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0}},
		'{lkv_pkg::ACT_GET, 16'h0000, 32'hFFFF_FFFF, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0, 16'h0}},
		'{lkv_pkg::ACT_PUT, 16'h0000, 32'hA5A5_A5A5, 1'b1,
			'{1'b1, 32'h0000_0000, 1'b0, 16'h0}},
		'{lkv_pkg::ACT_GET, 16'h0000, 32'h0000_0000, 1'b1,
			'{1'b1, 32'hA5A5_A5A5, 1'b0, 16'h0}},
		'{lkv_pkg::ACT_PUT, 16'h0001, 32'h1000_0001, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0002, 32'h2000_0002, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0003, 32'h3000_0003, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0004, 32'h4000_0004, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0005, 32'h5000_0005, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0006, 32'h6000_0006, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0007, 32'h7000_0007, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0008, 32'h8000_0008, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h0009, 32'h9000_0009, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h000A, 32'hA000_000A, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h000B, 32'hB000_000B, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h000C, 32'hC000_000C, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h000D, 32'hD000_000D, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h000E, 32'hE000_000E, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_PUT, 16'h8000, 32'h5A5A_5A5A, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_GET, 16'hFFFF, 32'h0000_0000, 1'b0, ZERO_RES},
		'{lkv_pkg::ACT_GET, 16'h0001, 32'h0000_0000, 1'b0, ZERO_RES}
	};

	localparam logic [lkv_pkg::CAP_W-1:0] CAP_STEPS [N_PHASES] = '{
		5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd17, 5'd8, 5'd2
	};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [lkv_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic                         s_tuser = 1'b0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [lkv_pkg::M_DATA_W-1:0] m_tdata;
	logic [lkv_pkg::M_USER_W-1:0] m_tuser;
	logic                         cfg_we = 1'b0;
	logic [lkv_pkg::CAP_W-1:0]    cfg_wdata = '0;

	logic row_typed = 1'b0;
	lkv_pkg::res_t row_expect = '0;

	logic [lkv_pkg::KEY_W-1:0]   cached_key [N_SLOTS];
	logic [lkv_pkg::VALUE_W-1:0] cached_value [N_SLOTS];
	logic                        cached_live [N_SLOTS];
	logic [3:0]                  lru_rank [N_SLOTS];
	logic [4:0]                  fill_level;
	logic [lkv_pkg::CAP_W-1:0]   capacity_reg;

	lkv_pkg::res_t awaited_results [$];
	logic [lkv_pkg::KEY_W-1:0] key_pool [24];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fault_count = 0;
	int requests_taken = 0;
	int results_checked = 0;
	int hits_seen = 0;
	int evictions_seen = 0;

	lru_key_value_cache dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Move slot s to the front; valid slots that were more recent age by one.
	function automatic void promote_slot(input int s);
		logic [3:0] old_rank;
		old_rank = lru_rank[s];
		for (int i = 0; i < N_SLOTS; i++) begin
			if (cached_live[i] && i != s && lru_rank[i] < old_rank)
				lru_rank[i]++;
		end
		lru_rank[s] = '0;
	endfunction

	function automatic lkv_pkg::res_t apply_access(input logic act,
			input logic [lkv_pkg::KEY_W-1:0] key,
			input logic [lkv_pkg::VALUE_W-1:0] val);
		lkv_pkg::res_t res;
		int slot;
		int free_slot;
		int limit;
		res = '0;
		slot = -1;
		free_slot = -1;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (slot < 0 && cached_live[i] && cached_key[i] == key)
				slot = i;
			if (free_slot < 0 && !cached_live[i])
				free_slot = i;
		end
		if (slot >= 0) begin
			res.hit = 1'b1;
			if (act == lkv_pkg::ACT_PUT)
				cached_value[slot] = val;
			else
				res.read_value = cached_value[slot];
			promote_slot(slot);
			return res;
		end
		if (act == lkv_pkg::ACT_GET)
			return res;
		limit = (capacity_reg == 0) ? 1 : (capacity_reg > N_SLOTS) ? N_SLOTS : capacity_reg;
		if (fill_level < limit && free_slot >= 0) begin
			for (int i = 0; i < N_SLOTS; i++) begin
				if (cached_live[i])
					lru_rank[i]++;
			end
			cached_live[free_slot] = 1'b1;
			cached_key[free_slot] = key;
			cached_value[free_slot] = val;
			lru_rank[free_slot] = '0;
			fill_level++;
			return res;
		end
		for (int i = 0; i < N_SLOTS; i++) begin
			if (cached_live[i] && (slot < 0 || lru_rank[i] > lru_rank[slot]))
				slot = i;
		end
		if (slot >= 0) begin
			res.evicted = 1'b1;
			res.evicted_key = cached_key[slot];
			cached_key[slot] = key;
			cached_value[slot] = val;
			promote_slot(slot);
		end
		return res;
	endfunction

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Check results first, then record the request taken at the same edge.
	always @(posedge clk) begin : monitor
		lkv_pkg::res_t got;
		lkv_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit = m_tuser[0];
			got.evicted = m_tuser[1];
			got.read_value = m_tdata[lkv_pkg::VALUE_W-1:0];
			got.evicted_key = m_tdata[lkv_pkg::VALUE_W +: lkv_pkg::KEY_W];
			results_checked++;
			if (got.hit)
				hits_seen++;
			if (got.evicted)
				evictions_seen++;
			if (awaited_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: hit=%0b read=%h evicted=%0b key=%h",
						got.hit, got.read_value, got.evicted, got.evicted_key);
			end else begin
				want = awaited_results.pop_front();
				if (got.hit !== want.hit || got.read_value !== want.read_value
						|| got.evicted !== want.evicted
						|| got.evicted_key !== want.evicted_key) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch at result %0d: expected hit=%0b read=%h ",
							results_checked, want.hit, want.read_value,
							"evicted=%0b key=%h, ", want.evicted, want.evicted_key,
							"got hit=%0b read=%h ", got.hit, got.read_value,
							"evicted=%0b key=%h", got.evicted, got.evicted_key);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			want = apply_access(s_tuser, s_tdata[lkv_pkg::KEY_W-1:0],
				s_tdata[lkv_pkg::KEY_W +: lkv_pkg::VALUE_W]);
			if (row_typed)
				want = row_expect;
			awaited_results.push_back(want);
			requests_taken++;
		end
	end

	task automatic send_request(input logic act, input logic [lkv_pkg::KEY_W-1:0] key,
			input logic [lkv_pkg::VALUE_W-1:0] val, input logic typed,
			input lkv_pkg::res_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {val, key};
		row_typed <= typed;
		row_expect <= want;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Hold off the sender until every pending result has been taken.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		capacity_reg = cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int span;
		int pick;
		logic [lkv_pkg::KEY_W-1:0] key;
		for (int i = 0; i < N_SLOTS; i++) begin
			cached_key[i] = '0;
			cached_value[i] = '0;
			cached_live[i] = 1'b0;
			lru_rank[i] = '0;
		end
		fill_level = '0;
		capacity_reg = lkv_pkg::CAP_W'(lkv_pkg::CAP_RESET);
		for (int i = 0; i < 24; i++)
			key_pool[i] = lkv_pkg::KEY_W'($urandom_range(65535));
		send_idle_pct = 6;
		recv_idle_pct = 54;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < N_PROBES; r++)
			send_request(PROBES[r].act, PROBES[r].key, PROBES[r].val, PROBES[r].typed,
				PROBES[r].want);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 6;
				recv_idle_pct = 54;
			end else if (p < 6) begin
				send_idle_pct = 54;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain_results();
			write_capacity(CAP_STEPS[p]);
			repeat (6) key_pool[$urandom_range(23)] = lkv_pkg::KEY_W'($urandom_range(65535));
			span = (capacity_reg == 0) ? 4 : (capacity_reg > N_SLOTS) ? N_SLOTS + 3
				: capacity_reg + 3;
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (p == 1 && n == PHASE_LEN / 2)
					drain_results();
				pick = $urandom_range(99);
				if (pick < 82)
					key = key_pool[$urandom_range(span - 1)];
				else if (pick < 94)
					key = lkv_pkg::KEY_W'($urandom_range(65535));
				else
					key = {lkv_pkg::KEY_W{pick[0]}};
				send_request(1'($urandom_range(1)), key, $urandom, 1'b0, ZERO_RES);
			end
		end

		drain_results();
		repeat (N_SLOTS + 8) @(posedge clk);
		$display("Ran %0d get/put requests over %0d capacity settings and three idle patterns.",
			requests_taken, N_PHASES + 1);
		$display("Results checked: %0d, with %0d hits and %0d evictions; faults: %0d.",
			results_checked, hits_seen, evictions_seen, fault_count);
		if (fault_count == 0 && awaited_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
sv/lkv_pkg.sv
sv/lkv_store.sv
sv/lkv_ctrl.sv
sv/lru_key_value_cache.sv
bench/lru_key_value_cache_test.sv
